// ===== design/ntt_pkg.sv =====
// ---------------------------------------------------------------------------
// ntt_pkg: shared types, constants and arithmetic for the q=3329 NTT block
// Holds the zeta table, command and result codes, and the reduction functions.
// ---------------------------------------------------------------------------
package ntt_pkg;

	localparam logic signed [15:0] MOD_Q = 16'sd3329;
	localparam logic signed [15:0] INV_SCALE = 16'sd1441;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_FWD  = 2'd1,
		CMD_INV  = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK  = 2'd0,
		KIND_DONE = 2'd1,
		KIND_DATA = 2'd2
	} kind_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  index;
		logic [15:0] value;
	} req_t;

	function automatic logic signed [15:0] zeta(input logic [6:0] k);
		logic signed [15:0] z;
		case (k)
			7'd0: z = -16'sd1044; 7'd1: z = -16'sd758; 7'd2: z = -16'sd359;
			7'd3: z = -16'sd1517; 7'd4: z = 16'sd1493; 7'd5: z = 16'sd1422;
			7'd6: z = 16'sd287; 7'd7: z = 16'sd202; 7'd8: z = -16'sd171;
			7'd9: z = 16'sd622; 7'd10: z = 16'sd1577; 7'd11: z = 16'sd182;
			7'd12: z = 16'sd962; 7'd13: z = -16'sd1202; 7'd14: z = -16'sd1474;
			7'd15: z = 16'sd1468; 7'd16: z = 16'sd573; 7'd17: z = -16'sd1325;
			7'd18: z = 16'sd264; 7'd19: z = 16'sd383; 7'd20: z = -16'sd829;
			7'd21: z = 16'sd1458; 7'd22: z = -16'sd1602; 7'd23: z = -16'sd130;
			7'd24: z = -16'sd681; 7'd25: z = 16'sd1017; 7'd26: z = 16'sd732;
			7'd27: z = 16'sd608; 7'd28: z = -16'sd1542; 7'd29: z = 16'sd411;
			7'd30: z = -16'sd205; 7'd31: z = -16'sd1571; 7'd32: z = 16'sd1223;
			7'd33: z = 16'sd652; 7'd34: z = -16'sd552; 7'd35: z = 16'sd1015;
			7'd36: z = -16'sd1293; 7'd37: z = 16'sd1491; 7'd38: z = -16'sd282;
			7'd39: z = -16'sd1544; 7'd40: z = 16'sd516; 7'd41: z = -16'sd8;
			7'd42: z = -16'sd320; 7'd43: z = -16'sd666; 7'd44: z = -16'sd1618;
			7'd45: z = -16'sd1162; 7'd46: z = 16'sd126; 7'd47: z = 16'sd1469;
			7'd48: z = -16'sd853; 7'd49: z = -16'sd90; 7'd50: z = -16'sd271;
			7'd51: z = 16'sd830; 7'd52: z = 16'sd107; 7'd53: z = -16'sd1421;
			7'd54: z = -16'sd247; 7'd55: z = -16'sd951; 7'd56: z = -16'sd398;
			7'd57: z = 16'sd961; 7'd58: z = -16'sd1508; 7'd59: z = -16'sd725;
			7'd60: z = 16'sd448; 7'd61: z = -16'sd1065; 7'd62: z = 16'sd677;
			7'd63: z = -16'sd1275; 7'd64: z = -16'sd1103; 7'd65: z = 16'sd430;
			7'd66: z = 16'sd555; 7'd67: z = 16'sd843; 7'd68: z = -16'sd1251;
			7'd69: z = 16'sd871; 7'd70: z = 16'sd1550; 7'd71: z = 16'sd105;
			7'd72: z = 16'sd422; 7'd73: z = 16'sd587; 7'd74: z = 16'sd177;
			7'd75: z = -16'sd235; 7'd76: z = -16'sd291; 7'd77: z = -16'sd460;
			7'd78: z = 16'sd1574; 7'd79: z = 16'sd1653; 7'd80: z = -16'sd246;
			7'd81: z = 16'sd778; 7'd82: z = 16'sd1159; 7'd83: z = -16'sd147;
			7'd84: z = -16'sd777; 7'd85: z = 16'sd1483; 7'd86: z = -16'sd602;
			7'd87: z = 16'sd1119; 7'd88: z = -16'sd1590; 7'd89: z = 16'sd644;
			7'd90: z = -16'sd872; 7'd91: z = 16'sd349; 7'd92: z = 16'sd418;
			7'd93: z = 16'sd329; 7'd94: z = -16'sd156; 7'd95: z = -16'sd75;
			7'd96: z = 16'sd817; 7'd97: z = 16'sd1097; 7'd98: z = 16'sd603;
			7'd99: z = 16'sd610; 7'd100: z = 16'sd1322; 7'd101: z = -16'sd1285;
			7'd102: z = -16'sd1465; 7'd103: z = 16'sd384; 7'd104: z = -16'sd1215;
			7'd105: z = -16'sd136; 7'd106: z = 16'sd1218; 7'd107: z = -16'sd1335;
			7'd108: z = -16'sd874; 7'd109: z = 16'sd220; 7'd110: z = -16'sd1187;
			7'd111: z = -16'sd1659; 7'd112: z = -16'sd1185; 7'd113: z = -16'sd1530;
			7'd114: z = -16'sd1278; 7'd115: z = 16'sd794; 7'd116: z = -16'sd1510;
			7'd117: z = -16'sd854; 7'd118: z = -16'sd870; 7'd119: z = 16'sd478;
			7'd120: z = -16'sd108; 7'd121: z = -16'sd308; 7'd122: z = 16'sd996;
			7'd123: z = 16'sd991; 7'd124: z = 16'sd958; 7'd125: z = -16'sd1460;
			7'd126: z = 16'sd1522; 7'd127: z = 16'sd1628;
			default: z = 16'sd0;
		endcase
		return z;
	endfunction

	// Montgomery reduction of a 32-bit product; two multiplies inside.
	function automatic logic signed [15:0] mont_reduce(input logic signed [31:0] a);
		logic [31:0]        lo;
		logic signed [15:0] t;
		logic signed [31:0] d;
		lo = {16'd0, a[15:0]} * 32'd62209;
		t = lo[15:0];
		d = a - t * 32'sd3329;
		return d[31:16];
	endfunction

	function automatic logic signed [15:0] barrett(input logic signed [15:0] a);
		logic signed [31:0] x;
		logic signed [15:0] t;
		logic signed [31:0] r;
		x = 32'sd20159 * 32'(a) + 32'sd33554432;
		t = 16'(x >>> 26);
		r = 32'(a) - 32'(t) * 32'sd3329;
		return r[15:0];
	endfunction

endpackage

// ===== design/ntt_forward_inverse_q3329.sv =====
// ---------------------------------------------------------------------------
// ntt_forward_inverse_q3329: 256-point NTT/INTT over q=3329
// Coefficient store with load, read, forward and inverse transform commands.
// ---------------------------------------------------------------------------
// Channel  | Handshake     | Fields
// request  | start / busy  | command, index, value
// result   | strobe        | kind, coefficient
// A load is written and acknowledged from the idle state; a read goes through
// the read state. A transform runs 7 layers of 128 butterflies plus a 256-entry
// final pass, each step going through read, multiply, reduce and write states
// on the one-read, one-write coefficient memory. Reset clears control only.
// Busy rises when the two-entry request queue is full; results cannot be stalled.
module ntt_forward_inverse_q3329 #(
	parameter int NUM_COEFFS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [7:0]         index,
	input  logic signed [15:0] value,
	output logic               strobe,
	output logic [1:0]         kind,
	output logic signed [15:0] coefficient
);
	logic          q_valid, q_pop;
	ntt_pkg::req_t q_head;
	logic          cfg_ok;
	assign cfg_ok = (NUM_COEFFS == 256);

	ntt_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start && cfg_ok), .command(command),
		.index(index), .value(value), .busy(busy), .q_valid(q_valid),
		.q_head(q_head), .q_pop(q_pop)
	);

	ntt_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head),
		.q_pop(q_pop), .strobe(strobe), .kind(kind), .coefficient(coefficient)
	);
endmodule

// ===== design/ntt_front.sv =====
// ---------------------------------------------------------------------------
// ntt_front: command intake
// Accepts requests and pushes them into a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module ntt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     command,
	input  logic [7:0]     index,
	input  logic [15:0]    value,
	output logic           busy,
	output logic           q_valid,
	output ntt_pkg::req_t  q_head,
	input  logic           q_pop
);
	ntt_pkg::req_t entry_q [2];
	logic          rd_q, wr_q;
	logic [1:0]    count_q;
	logic          push;

	assign busy = (count_q == 2'd2);
	assign push = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign q_head = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= '{ntt_pkg::cmd_t'(command), index, value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ===== design/ntt_back.sv =====
// ---------------------------------------------------------------------------
// ntt_back: coefficient memory and transform sequencer
// Executes queued requests; butterflies run as read, multiply, reduce, write steps.
// ---------------------------------------------------------------------------
module ntt_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  ntt_pkg::req_t         q_head,
	output logic                  q_pop,
	output logic                  strobe,
	output logic [1:0]            kind,
	output logic signed [15:0]    coefficient
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_RDA  = 8'b00000010,
		S_RDB  = 8'b00000100,
		S_MUL  = 8'b00001000,
		S_RED  = 8'b00010000,
		S_WRA  = 8'b00100000,
		S_WRB  = 8'b01000000,
		S_READ = 8'b10000000
	} state_t;

	state_t             state_q;
	logic               inv_q, post_q;
	logic [2:0]         layer_q;
	logic [7:0]         j_q;
	logic [6:0]         k_q;
	logic signed [15:0] mem [256];
	logic signed [15:0] rdata_q, a_q, b_q, p_q, ra_q, rb_q;
	logic signed [31:0] prod_q;
	logic               we;
	logic [7:0]         waddr, raddr;
	logic signed [15:0] wdata;
	logic [7:0]         len, addr_b;
	logic signed [15:0] diff;

	assign len = 8'd128 >> (inv_q ? 3'd6 - layer_q : layer_q);
	assign addr_b = j_q | len;
	// The difference wraps in 16 bits before it reaches the multiplier.
	assign diff = rdata_q - a_q;

	always_comb begin
		raddr = j_q;
		case (state_q)
			S_IDLE:  raddr = q_head.index;
			S_RDB:   raddr = addr_b;
			default: raddr = j_q;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = j_q;
		wdata = ra_q;
		case (state_q)
			S_IDLE: begin
				we = q_valid && q_head.cmd == ntt_pkg::CMD_LOAD;
				waddr = q_head.index;
				wdata = q_head.value;
			end
			S_WRA: we = 1'b1;
			S_WRB: begin
				we = !post_q;
				waddr = addr_b;
				wdata = rb_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// Datapath: the multiply and the Montgomery reduction each get a register stage; Barrett is combinational.
	always_ff @(posedge clk) begin
		case (state_q)
			S_RDB: a_q <= rdata_q;
			S_MUL: begin
				b_q <= rdata_q;
				if (post_q) prod_q <= 32'(a_q) * 32'(inv_q ? ntt_pkg::INV_SCALE
					: 16'sd1);
				else if (inv_q) prod_q <= 32'(ntt_pkg::zeta(k_q)) * 32'(diff);
				else prod_q <= 32'(ntt_pkg::zeta(k_q)) * 32'(rdata_q);
			end
			S_RED: p_q <= ntt_pkg::mont_reduce(prod_q);
			S_WRA: ;
			default: ;
		endcase
	end

	always_comb begin
		ra_q = a_q;
		rb_q = p_q;
		if (post_q) ra_q = inv_q ? p_q : ntt_pkg::barrett(a_q);
		else if (inv_q) ra_q = ntt_pkg::barrett(a_q + b_q);
		else begin
			ra_q = a_q + p_q;
			rb_q = a_q - p_q;
		end
	end

	logic               last_j;
	logic [7:0]         j_next;
	// Step to the next low index, skipping the upper half of each block, or to the
	// next index in the final pass; the index wraps to zero at the end of a pass.
	assign j_next = post_q ? j_q + 8'd1 : ((j_q | len) + 8'd1) & ~len;
	assign last_j = post_q ? (j_q == 8'd255) : ((j_q | len) == 8'd255);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			inv_q <= 1'b0;
			post_q <= 1'b0;
			layer_q <= 3'd0;
			j_q <= 8'd0;
			k_q <= 7'd0;
			strobe <= 1'b0;
			kind <= 2'd0;
			coefficient <= 16'sd0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_IDLE: if (q_valid) begin
					case (q_head.cmd)
						ntt_pkg::CMD_LOAD: begin
							strobe <= 1'b1;
							kind <= ntt_pkg::KIND_ACK;
							coefficient <= 16'sd0;
						end
						ntt_pkg::CMD_READ: state_q <= S_READ;
						default: begin
							inv_q <= (q_head.cmd == ntt_pkg::CMD_INV);
							post_q <= 1'b0;
							layer_q <= 3'd0;
							j_q <= 8'd0;
							k_q <= (q_head.cmd == ntt_pkg::CMD_INV) ? 7'd127 : 7'd1;
							state_q <= S_RDA;
						end
					endcase
				end
				S_READ: begin
					strobe <= 1'b1;
					kind <= ntt_pkg::KIND_DATA;
					coefficient <= rdata_q;
					state_q <= S_IDLE;
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_MUL;
				S_MUL: state_q <= S_RED;
				S_RED: state_q <= S_WRA;
				S_WRA: state_q <= S_WRB;
				S_WRB: begin
					state_q <= S_RDA;
					j_q <= j_next;
					if (!post_q && (((j_q + 8'd1) & (len - 8'd1)) == 8'd0))
						k_q <= inv_q ? k_q - 7'd1 : k_q + 7'd1;
					if (last_j) begin
						if (post_q) begin
							state_q <= S_IDLE;
							strobe <= 1'b1;
							kind <= ntt_pkg::KIND_DONE;
							coefficient <= 16'sd0;
						end else if (layer_q == 3'd6) post_q <= 1'b1;
						else layer_q <= layer_q + 3'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
endmodule

// ===== design/ntt_checker.sv =====
// ---------------------------------------------------------------------------
// ntt_checker: port-level checks
// Watches the result strobe and payload of the NTT block.
// ---------------------------------------------------------------------------
module ntt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               strobe,
	input logic [1:0]         kind,
	input logic signed [15:0] coefficient
);
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (kind == ntt_pkg::KIND_ACK || kind == ntt_pkg::KIND_DONE
		|| kind == ntt_pkg::KIND_DATA)) else $error("bad result kind");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind != ntt_pkg::KIND_DATA |-> coefficient == 16'sd0)
		else $error("nonzero payload");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == ntt_pkg::KIND_DATA |=> !(strobe && kind == ntt_pkg::KIND_DATA))
		else $error("read too fast");
	a_rst: assert property (@(posedge clk) !arst_n |=> !strobe) else $error("strobe in reset");
endmodule

bind ntt_forward_inverse_q3329 ntt_checker u_checker (
	.clk(clk), .arst_n(arst_n), .strobe(strobe),
	.kind(kind), .coefficient(coefficient)
);
